### hw/rtl/rpdh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rpdh_pkg;

  localparam int ELEMENTS = 4096;
  localparam int ADDR_W   = $clog2(ELEMENTS);
  localparam int IDX_W    = 12;
  localparam int WIDE_W   = IDX_W + ADDR_W;
  localparam int POWER_W  = 32;
  localparam int TOTAL_W  = 48;
  localparam int AMT_W    = POWER_W + 1;

  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

  typedef enum logic [0:0] {
    OP_DEPOSIT = 1'b0,
    OP_READ    = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } state_t;

endpackage
`default_nettype wire

### hw/rtl/rpdh_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rpdh_in_if;
  import rpdh_pkg::*;

  logic                valid;
  logic                ready;
  op_t                 op;
  logic [IDX_W-1:0]    element_index;
  logic                element_present;
  logic [POWER_W-1:0]  ray_power;
  logic                first_point;
  logic                only_point;

  modport source (
    output valid, op, element_index, element_present, ray_power, first_point, only_point,
    input  ready
  );

  modport sink (
    input  valid, op, element_index, element_present, ray_power, first_point, only_point,
    output ready
  );

endinterface
`default_nettype wire

### hw/rtl/rpdh_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rpdh_out_if;
  import rpdh_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [IDX_W-1:0]           read_index;
  logic signed [TOTAL_W-1:0]  deposited_total;

  modport source (
    output valid, read_index, deposited_total,
    input  ready
  );

  modport sink (
    input  valid, read_index, deposited_total,
    output ready
  );

endinterface
`default_nettype wire

### hw/rtl/rpdh_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rpdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ray_power_deposit_histogram_top.sv
// Power deposit histogram: each accepted word is either an intersection deposit or a
// read-and-clear of one element accumulator. Words are taken one per cycle; a deposit
// gives no result, a read gives one result via the stage-1 and output registers. Every
// word is one read-modify-write of the accumulator RAM (registered read), with the
// previous write forwarded, so back-to-back hits on the same element run at full rate.
// Out of the clear sweep, input stalls only while a read result waits in the output
// register and a second read sits behind it. After reset the RAM is swept to zero, one
// entry per cycle, and no word is accepted until the sweep is done.
`timescale 1ns / 1ps
`default_nettype none
module ray_power_deposit_histogram_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rpdh_in_if.sink     in_ch,
  rpdh_out_if.source  out_ch
);
  import rpdh_pkg::*;

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic clearing;

  logic [POWER_W-1:0] prev_power_r;

  logic                     s1_valid_r;
  op_t                      s1_op_r;
  logic [ADDR_W-1:0]        s1_addr_r;
  logic [IDX_W-1:0]         s1_idx_r;
  logic                     s1_range_r;
  logic                     s1_dep_r;
  logic signed [AMT_W-1:0]  s1_amt_r;

  logic                     wb_valid_r;
  logic [ADDR_W-1:0]        wb_addr_r;
  logic [TOTAL_W-1:0]       wb_data_r;

  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_idx_r;
  logic signed [TOTAL_W-1:0] out_total_r;

  logic                     in_acc;
  logic [WIDE_W-1:0]        in_wide;
  logic [ADDR_W-1:0]        in_addr;
  logic                     in_range;
  logic signed [AMT_W-1:0]  in_amt;
  logic                     in_dep;

  logic                     s1_hold;
  logic                     s1_adv;
  logic                     s1_write;
  logic signed [TOTAL_W-1:0] base;
  logic signed [TOTAL_W:0]  sum;
  logic signed [TOTAL_W-1:0] sat_sum;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [TOTAL_W-1:0]       ram_wdata;
  logic [TOTAL_W-1:0]       ram_rdata;

  // clear sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(ELEMENTS - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: ;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    case (state_r)
      ST_CLEAR: clearing = 1'b1;
      ST_RUN:   clearing = 1'b0;
      default:  clearing = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // intake
  assign s1_hold = s1_valid_r && (s1_op_r == OP_READ) && out_valid_r && !out_ch.ready;
  assign s1_adv  = s1_valid_r && !s1_hold;
  assign in_ch.ready = !clearing && !s1_hold;
  assign in_acc  = in_ch.valid && in_ch.ready;

  assign in_wide  = {{ADDR_W{1'b0}}, in_ch.element_index};
  assign in_addr  = in_wide[ADDR_W-1:0];
  assign in_range = in_wide < WIDE_W'(ELEMENTS);

  always_comb begin
    if (in_ch.only_point) begin
      in_amt = $signed({1'b0, in_ch.ray_power});
    end else begin
      in_amt = $signed({1'b0, prev_power_r}) - $signed({1'b0, in_ch.ray_power});
    end
  end

  assign in_dep = (in_ch.op == OP_DEPOSIT) && in_ch.element_present && in_range &&
                  (in_ch.only_point || !in_ch.first_point);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_power_r <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      if (in_acc && (in_ch.op == OP_DEPOSIT)) begin
        prev_power_r <= in_ch.ray_power;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_ch.op;
      s1_addr_r  <= in_addr;
      s1_idx_r   <= in_ch.element_index;
      s1_range_r <= in_range;
      s1_dep_r   <= in_dep;
      s1_amt_r   <= in_amt;
    end
  end

  // modify: forward the last write, it may have hit the entry just read
  assign base = (wb_valid_r && (wb_addr_r == s1_addr_r)) ? $signed(wb_data_r)
                                                          : $signed(ram_rdata);
  assign sum  = $signed({base[TOTAL_W-1], base}) + (TOTAL_W + 1)'(s1_amt_r);

  always_comb begin
    if (sum[TOTAL_W] != sum[TOTAL_W-1]) begin
      sat_sum = sum[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX;
    end else begin
      sat_sum = sum[TOTAL_W-1:0];
    end
  end

  assign s1_write = s1_adv && (((s1_op_r == OP_READ) && s1_range_r) || s1_dep_r);

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_write;
      ram_waddr = s1_addr_r;
      ram_wdata = (s1_op_r == OP_READ) ? '0 : sat_sum;
    end
  end

  rpdh_ram #(
    .WIDTH (TOTAL_W),
    .DEPTH (ELEMENTS)
  ) u_totals (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_valid_r <= 1'b0;
    end else if (!clearing && s1_write) begin
      wb_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!clearing && s1_write) begin
      wb_addr_r <= ram_waddr;
      wb_data_r <= ram_wdata;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && (s1_op_r == OP_READ)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (s1_op_r == OP_READ)) begin
      out_idx_r   <= s1_idx_r;
      out_total_r <= s1_range_r ? base : '0;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.read_index      = out_idx_r;
  assign out_ch.deposited_total = out_total_r;

  a_read_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (s1_op_r == OP_READ) |=> out_valid_r)
    else $error("read left the pipeline without a result word");

  a_hold_blocks_intake: assert property (@(posedge clk) disable iff (!rst_n)
    s1_hold |-> !in_ch.ready)
    else $error("word accepted while stage 1 is held");

  a_run_write_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && !clearing |-> s1_valid_r)
    else $error("accumulator write without a word in stage 1");

  a_no_intake_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_acc && !s1_valid_r)
    else $error("word taken during clearing sweep");

  a_oor_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (s1_op_r == OP_READ) && !s1_range_r |=> out_total_r == '0)
    else $error("out-of-range read returned nonzero");

endmodule
`default_nettype wire

### dv/ray_power_deposit_histogram_top_test.sv
`timescale 1ns / 1ps
module ray_power_deposit_histogram_top_test;
  import rpdh_pkg::*;

  localparam int SAT_NEG_ELEM = 100;
  localparam int SAT_POS_ELEM = 101;
  localparam int SAT_PAIRS    = 64;
  localparam int RANDOM_WORDS = 1400;

  typedef struct {
    op_t                op;
    logic [IDX_W-1:0]   idx;
    logic               present;
    logic [POWER_W-1:0] power;
    logic               first;
    logic               only;
  } hit_word_t;

  typedef struct {
    logic [IDX_W-1:0]          idx;
    logic signed [TOTAL_W-1:0] total;
  } readback_t;

  logic clk;
  logic rst_n;

  rpdh_in_if  in_ch ();
  rpdh_out_if out_ch ();

  ray_power_deposit_histogram_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hit_word_t ray_words [$];
  readback_t readbacks [$];

  logic signed [TOTAL_W-1:0] model_totals [ELEMENTS] = '{default: '0};
  logic [POWER_W-1:0]        model_prev = '0;

  hit_word_t launch_word;
  hit_word_t seen_word;
  readback_t want;

  int gap_left;
  int stall_left;
  int quiet_in;
  int quiet_out;
  int mismatches;
  int deposits_seen;
  int readbacks_seen;
  int rays_seen;
  int clamp_high;
  int clamp_low;

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = ~clk;
  end

  function automatic int idle_len(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 999);
    // start a stretch with no idling now and then
    if (r < 5) begin
      quiet = $urandom_range(40, 300);
      return 0;
    end
    if (r < 550) return 0;
    if (r < 850) return $urandom_range(1, 3);
    if (r < 970) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_word(input op_t op, input int idx, input bit present,
                           input logic [POWER_W-1:0] power, input bit first, input bit only);
    hit_word_t w;
    w.op      = op;
    w.idx     = idx[IDX_W-1:0];
    w.present = present;
    w.power   = power;
    w.first   = first;
    w.only    = only;
    ray_words.push_back(w);
  endtask

  // Update the accumulator image for one accepted word; queue the readback of a read.
  task automatic absorb(input hit_word_t w);
    longint    amount;
    longint    sum;
    bit        do_add;
    readback_t rb;
    if (w.op == OP_READ) begin
      rb.idx   = w.idx;
      rb.total = '0;
      if (w.idx < ELEMENTS) begin
        rb.total = model_totals[w.idx];
        model_totals[w.idx] = '0;
      end
      readbacks.push_back(rb);
    end else begin
      deposits_seen++;
      do_add = 1'b0;
      amount = 0;
      if (w.only) begin
        rays_seen++;
        do_add = w.present;
        amount = longint'({32'd0, w.power});
      end else if (!w.first) begin
        do_add = w.present;
        amount = longint'({32'd0, model_prev}) - longint'({32'd0, w.power});
      end else begin
        rays_seen++;
      end
      if (do_add && w.idx < ELEMENTS) begin
        sum = longint'(model_totals[w.idx]) + amount;
        if (sum > longint'(TOTAL_MAX)) begin
          sum = longint'(TOTAL_MAX);
          clamp_high++;
        end
        if (sum < longint'(TOTAL_MIN)) begin
          sum = longint'(TOTAL_MIN);
          clamp_low++;
        end
        model_totals[w.idx] = sum[TOTAL_W-1:0];
      end
      model_prev = w.power;
    end
  endtask

  // Driver: hold the word until taken, then wait out the gap before the next.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (ray_words.size() > 0) begin
        launch_word = ray_words.pop_front();
        in_ch.valid           <= 1'b1;
        in_ch.op              <= launch_word.op;
        in_ch.element_index   <= launch_word.idx;
        in_ch.element_present <= launch_word.present;
        in_ch.ray_power       <= launch_word.power;
        in_ch.first_point     <= launch_word.first;
        in_ch.only_point      <= launch_word.only;
        gap_left = idle_len(quiet_in);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: predict on every accepted input word, check every accepted readback.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        seen_word.op      = in_ch.op;
        seen_word.idx     = in_ch.element_index;
        seen_word.present = in_ch.element_present;
        seen_word.power   = in_ch.ray_power;
        seen_word.first   = in_ch.first_point;
        seen_word.only    = in_ch.only_point;
        absorb(seen_word);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (readbacks.size() == 0) begin
          mismatches++;
          $display("%0t: readback with none outstanding: expected none, actual element %0d total %0d",
                   $time, out_ch.read_index, out_ch.deposited_total);
        end else begin
          want = readbacks.pop_front();
          readbacks_seen++;
          if (out_ch.read_index !== want.idx) begin
            mismatches++;
            $display("%0t: read_index mismatch: expected %0d, actual %0d",
                     $time, want.idx, out_ch.read_index);
          end
          if (out_ch.deposited_total !== want.total) begin
            mismatches++;
            $display("%0t: deposited_total mismatch on element %0d: expected %0d, actual %0d",
                     $time, want.idx, want.total, out_ch.deposited_total);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = idle_len(quiet_out);
      end
    end
  end

  initial begin
    int          pick;
    int          len;
    int          k;
    int          n;
    int          idx;
    int          random_words;
    int          hot [16];
    logic [31:0] pwr;

    in_ch.valid           = 1'b0;
    in_ch.op              = OP_DEPOSIT;
    in_ch.element_index   = '0;
    in_ch.element_present = 1'b0;
    in_ch.ray_power       = '0;
    in_ch.first_point     = 1'b0;
    in_ch.only_point      = 1'b0;
    out_ch.ready          = 1'b0;
    rst_n                 = 1'b0;

    // directed: single-point rays, multi-point drops both ways, absent elements,
    // a read with junk fields in the middle of a ray, field extremes
    push_word(OP_READ,    0,    0, 32'h0000_0000, 0, 0);
    push_word(OP_DEPOSIT, 0,    1, 32'hFFFF_FFFF, 1, 1);
    push_word(OP_DEPOSIT, 4095, 1, 32'h0001_0000, 0, 1);
    push_word(OP_DEPOSIT, 5,    0, 32'h0000_007B, 1, 1);
    push_word(OP_DEPOSIT, 7,    1, 32'h0008_0000, 1, 0);
    push_word(OP_DEPOSIT, 7,    1, 32'h0003_0000, 0, 0);
    push_word(OP_DEPOSIT, 7,    0, 32'h0002_0000, 0, 0);
    push_word(OP_DEPOSIT, 7,    1, 32'h0005_0000, 0, 0);
    push_word(OP_READ,    7,    1, 32'hFFFF_FFFF, 1, 1);
    push_word(OP_DEPOSIT, 4095, 1, 32'h0000_0000, 0, 0);
    push_word(OP_DEPOSIT, 9,    1, 32'h0000_0000, 1, 0);
    push_word(OP_DEPOSIT, 9,    1, 32'hFFFF_FFFF, 0, 0);
    push_word(OP_DEPOSIT, 2730, 1, 32'hAAAA_AAAA, 1, 1);
    push_word(OP_DEPOSIT, 1365, 1, 32'h5555_5555, 0, 1);
    push_word(OP_READ,    0,    0, 32'h0000_0000, 0, 0);
    push_word(OP_READ,    4095, 0, 32'h0000_0000, 0, 0);
    push_word(OP_READ,    5,    0, 32'h0000_0000, 0, 0);
    push_word(OP_READ,    7,    0, 32'h0000_0000, 0, 0);
    push_word(OP_READ,    9,    0, 32'h0000_0000, 0, 0);
    push_word(OP_READ,    2730, 0, 32'h0000_0000, 0, 0);
    push_word(OP_READ,    1365, 0, 32'h0000_0000, 0, 0);

    // random: mostly well-formed rays over a hot set of elements, read bursts, noise
    hot[0] = 0;
    hot[1] = ELEMENTS - 1;
    for (k = 2; k < 16; k++) hot[k] = $urandom_range(0, ELEMENTS - 1);
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
        pwr = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
        for (k = 0; k < len; k++) begin
          if (k > 0) begin
            // mostly losing power along the ray, now and then a jump
            if ($urandom_range(0, 9) < 8) pwr = pwr - ($urandom % ((pwr >> 2) + 1));
            else pwr = $urandom;
          end
          idx = ($urandom_range(0, 9) < 7) ? hot[$urandom_range(0, 15)]
                                           : $urandom_range(0, ELEMENTS - 1);
          push_word(OP_DEPOSIT, idx, $urandom_range(0, 99) < 85, pwr,
                    (len == 1) ? 1'($urandom_range(0, 1)) : (k == 0), len == 1);
        end
        random_words += len;
      end else if (pick < 85) begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
          idx = ($urandom_range(0, 9) < 7) ? hot[$urandom_range(0, 15)]
                                           : $urandom_range(0, ELEMENTS - 1);
          push_word(OP_READ, idx, 1'($urandom_range(0, 1)), $urandom,
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        random_words += n;
      end else begin
        push_word(op_t'($urandom_range(0, 1)), $urandom_range(0, ELEMENTS - 1),
                  1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        random_words++;
      end
    end
    for (k = 0; k < 16; k++) push_word(OP_READ, hot[k], 0, 32'h0, 0, 0);

    // swing: one long ray at full scale, alternating big gains and losses on two elements
    push_word(OP_READ, SAT_NEG_ELEM, 0, 32'h0, 0, 0);
    push_word(OP_READ, SAT_POS_ELEM, 0, 32'h0, 0, 0);
    push_word(OP_DEPOSIT, SAT_NEG_ELEM, 1, 32'hFFFF_FFFF, 1, 0);
    for (k = 0; k < SAT_PAIRS; k++) begin
      push_word(OP_DEPOSIT, SAT_POS_ELEM, 1, 32'h0000_0000, 0, 0);
      push_word(OP_DEPOSIT, SAT_NEG_ELEM, 1, 32'hFFFF_FFFF, 0, 0);
    end
    push_word(OP_DEPOSIT, SAT_POS_ELEM, 1, 32'h0000_0000, 0, 0);
    push_word(OP_READ, SAT_NEG_ELEM, 0, 32'h0, 0, 0);
    push_word(OP_DEPOSIT, SAT_POS_ELEM, 1, 32'h0001_0000, 0, 0);
    push_word(OP_READ, SAT_POS_ELEM, 0, 32'h0, 0, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // sample away from the active edge
    @(negedge clk);
    while (ray_words.size() != 0 || in_ch.valid || readbacks.size() != 0) @(negedge clk);
    repeat (16) @(posedge clk);

    $display("covered %0d deposit words over %0d rays and %0d checked readbacks",
             deposits_seen, rays_seen, readbacks_seen);
    $display("accumulator clamp taken %0d times at the top bound and %0d at the bottom",
             clamp_high, clamp_low);
    if (mismatches == 0) begin
      $display("ray_power_deposit_histogram_top_test: done, clean");
    end else begin
      $display("ray_power_deposit_histogram_top_test: done, errors");
    end
    $finish;
  end

  initial begin
    #240_000_000;
    $display("timeout with %0d words unsent and %0d readbacks outstanding",
             ray_words.size(), readbacks.size());
    $display("ray_power_deposit_histogram_top_test: done, errors");
    $finish;
  end

endmodule
